// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion helpers for the lbp window encoder
// both macros expect clk in scope, LBP_ASSERT also expects arst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// checked only out of reset
`define LBP_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("lbp assertion failed");
// checked during reset as well
`define LBP_ASSERT_RST(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("lbp reset assertion failed");
`else
`define LBP_ASSERT(label, prop)
`define LBP_ASSERT_RST(label, prop)
`endif

`endif

// ===== src/lbp_pkg.sv =====
// ---------------------------------------------------------------------------
// lbp_pkg
// shared types and constants of the 3x3 local binary pattern encoder
// ---------------------------------------------------------------------------
package lbp_pkg;

	localparam int PIX_W   = 8;
	localparam int ROW_W   = 12;
	localparam int COL_W   = 10;
	localparam int CFG_W   = 11;
	localparam int ENTRY_W = 2 * PIX_W;

	localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 11'd640;
	localparam logic [CFG_W-1:0] LINE_WIDTH_MIN   = 11'd3;

	typedef logic [PIX_W-1:0]   pix_t;
	typedef logic [ENTRY_W-1:0] entry_t;

	// input beat
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             frame_start;
	} pix_beat_t;

	// output beat
	typedef struct packed {
		logic [PIX_W-1:0] lbp_code;
		logic [ROW_W-1:0] center_row;
		logic [COL_W-1:0] center_col;
	} code_beat_t;

	// item passed from the address stage to the window stage
	typedef struct packed {
		pix_t             pixel;
		logic             emit;
		logic [ROW_W-1:0] center_row;
		logic [COL_W-1:0] center_col;
	} stage_t;

endpackage

// ===== src/lbp_window_encoder_core.sv =====
// ---------------------------------------------------------------------------
// lbp_window_encoder_core
// 3x3 local binary pattern encoder over a raster stream of grey pixels
// ---------------------------------------------------------------------------
// pix channel: one pixel per beat in raster order, frame_start on the first
// pixel of a frame restarts row and column at zero
// code channel: one beat per interior pixel, the code of the centre one row
// up and one column left of the pixel just taken, with its row and column
// cfg_we/cfg_wdata: line width, written by user only while the block is idle
// not enforced by the block; below 3 acts as 3, above MAX_WIDTH as MAX_WIDTH
// throughput: one pixel per cycle outside a stall, set by the single read
// and single write port of the line store, one read-modify-write of its entry
// per pixel; a pixel and its entry are registered on the taking edge, then
// window and compare feed the output register once it is free
// reset: counters and window clear, line width back to 640; line store
// contents are undefined and only written entries feed an emitted code
// stall: while a code waits, one more pixel is taken and held at the
// window stage, after that pix_ready drops until the code is taken
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lbp_window_encoder_core #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lbp_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                             pix_valid,
	output logic                             pix_ready,
	input  lbp_pkg::pix_beat_t               pix,
	output logic                             code_valid,
	input  logic                             code_ready,
	output lbp_pkg::code_beat_t              code
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	// wide enough for MAX_WIDTH itself and for the register
	localparam int LW = ((AW + 1) > lbp_pkg::CFG_W) ? (AW + 1) : lbp_pkg::CFG_W;
	localparam logic [LW-1:0] MAX_W_L = LW'(MAX_WIDTH);
	localparam logic [LW-1:0] MIN_W_L = LW'(lbp_pkg::LINE_WIDTH_MIN);
	localparam logic [AW-1:0] COL_ONE = AW'(1);

	logic [lbp_pkg::CFG_W-1:0] line_width_q;
	logic [LW-1:0]             width_ext;
	logic [LW-1:0]             eff_width;

	logic [lbp_pkg::ROW_W-1:0] row_q;
	logic [AW-1:0]             col_q;
	logic [lbp_pkg::ROW_W-1:0] r;
	logic [AW-1:0]             c;
	logic [LW-1:0]             c_ext;
	logic                      row_end;

	logic                      pix_accept;
	logic                      advance;
	logic                      valid_s1;
	logic [AW-1:0]             addr_s1;
	lbp_pkg::stage_t           item_s1;
	lbp_pkg::stage_t           item_s0;

	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	lbp_pkg::entry_t           rd_data;
	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	lbp_pkg::entry_t           wr_data;

	// line width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= lbp_pkg::LINE_WIDTH_RESET;
		end else if (cfg_we) begin
			line_width_q <= cfg_wdata;
		end
	end

	assign width_ext = LW'(line_width_q);
	assign eff_width = (width_ext < MIN_W_L) ? MIN_W_L :
		(width_ext > MAX_W_L) ? MAX_W_L : width_ext;

	// handshake: stage one moves whenever the output register is free
	assign advance    = valid_s1 && (!code_valid || code_ready);
	assign pix_ready  = !valid_s1 || !code_valid || code_ready;
	assign pix_accept = pix_valid && pix_ready;

	// position of the incoming pixel
	assign r       = pix.frame_start ? '0 : row_q;
	assign c       = pix.frame_start ? '0 : col_q;
	assign c_ext   = LW'(c);
	assign row_end = (c_ext + LW'(1)) >= eff_width;

	always_comb begin
		item_s0.pixel      = pix.pixel;
		item_s0.emit       = (r >= lbp_pkg::ROW_W'(2)) && (c_ext >= LW'(2)) &&
			(c_ext < eff_width);
		item_s0.center_row = r - lbp_pkg::ROW_W'(1);
		item_s0.center_col = lbp_pkg::COL_W'(c_ext - LW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (pix_accept) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= r + lbp_pkg::ROW_W'(1);
				end else begin
					col_q <= c + COL_ONE;
					row_q <= r;
				end
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			item_s1 <= item_s0;
			addr_s1 <= c;
		end
	end

	assign rd_en   = pix_accept;
	assign rd_addr = c;
	assign wr_en   = advance;
	assign wr_addr = addr_s1;

	lbp_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_line_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	lbp_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item       (item_s1),
		.rd_data    (rd_data),
		.wb_data    (wr_data),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code       (code)
	);

	// input stalls only behind a held item and a blocked output
	`LBP_ASSERT(a_stall_cause, !pix_ready |-> valid_s1 && code_valid && !code_ready)
	// a frame start beat is column zero of row zero
	`LBP_ASSERT(a_frame_restart, pix_accept && pix.frame_start |=> row_q == '0 && col_q == COL_ONE)
	// same-entry read and write in one cycle returns the new entry
	`LBP_ASSERT(a_bypass, rd_en && wr_en && (rd_addr == wr_addr) |=> rd_data == $past(wr_data))
	// no code for the first row
	`LBP_ASSERT(a_row_interior, code_valid |-> code.center_row != '0)
	// nothing in flight while reset is held
	`LBP_ASSERT_RST(a_reset_idle, !arst_n |-> !code_valid && !valid_s1)

endmodule

// ===== src/lbp_line_store.sv =====
// ---------------------------------------------------------------------------
// lbp_line_store
// both line stores in one memory, entry = {upper, middle}, registered read
// with write-to-read bypass on a same-address collision
// ---------------------------------------------------------------------------
module lbp_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output lbp_pkg::entry_t      rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  lbp_pkg::entry_t      wr_data
);

	lbp_pkg::entry_t mem [DEPTH];
	lbp_pkg::entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== src/lbp_window.sv =====
// ---------------------------------------------------------------------------
// lbp_window
// 3x3 window shift, eight compares against the centre and the output register
// ---------------------------------------------------------------------------
module lbp_window (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  lbp_pkg::stage_t      item,
	input  lbp_pkg::entry_t      rd_data,
	output lbp_pkg::entry_t      wb_data,
	output logic                 code_valid,
	input  logic                 code_ready,
	output lbp_pkg::code_beat_t  code
);

	lbp_pkg::pix_t win_q [3][3];
	lbp_pkg::pix_t win_nx [3][3];
	lbp_pkg::pix_t top;
	lbp_pkg::pix_t mid;
	lbp_pkg::pix_t ctr;
	logic [lbp_pkg::PIX_W-1:0] bits;
	logic                 valid_q;
	lbp_pkg::code_beat_t  code_q;

	assign top = rd_data[lbp_pkg::ENTRY_W-1:lbp_pkg::PIX_W];
	assign mid = rd_data[lbp_pkg::PIX_W-1:0];

	// row above moves up, new pixel becomes the middle row
	assign wb_data = {mid, item.pixel};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_nx[i][0] = win_q[i][1];
			win_nx[i][1] = win_q[i][2];
		end
		win_nx[0][2] = top;
		win_nx[1][2] = mid;
		win_nx[2][2] = item.pixel;
	end

	assign ctr = win_nx[1][1];

	always_comb begin
		bits[0] = win_nx[0][0] >= ctr;
		bits[1] = win_nx[0][1] >= ctr;
		bits[2] = win_nx[0][2] >= ctr;
		bits[3] = win_nx[1][0] >= ctr;
		bits[4] = win_nx[1][2] >= ctr;
		bits[5] = win_nx[2][0] >= ctr;
		bits[6] = win_nx[2][1] >= ctr;
		bits[7] = win_nx[2][2] >= ctr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
			valid_q <= 1'b0;
		end else if (advance) begin
			win_q   <= win_nx;
			valid_q <= item.emit;
		end else if (code_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			code_q.lbp_code   <= bits;
			code_q.center_row <= item.center_row;
			code_q.center_col <= item.center_col;
		end
	end

	assign code_valid = valid_q;
	assign code       = code_q;

endmodule
